// ===== hw/rtl/ecpc_pkg.sv =====
// ecpc_pkg: shared types and constants of the echo payload pattern checker
// (verdict codes, item kinds, register indexes, pattern generator constants)
// no dependencies
`default_nettype none

package ecpc_pkg;

  // item kind carried in tuser
  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // verdict codes
  typedef enum logic [2:0] {
    VERDICT_GOOD     = 3'd0,
    VERDICT_CHECKSUM = 3'd1,
    VERDICT_LENGTH   = 3'd2,
    VERDICT_FRAME    = 3'd3,
    VERDICT_TYPE     = 3'd4,
    VERDICT_PAYLOAD  = 3'd5
  } verdict_t;

  // pattern modes
  typedef enum logic [1:0] {
    PAT_ZERO  = 2'd0,
    PAT_INCR  = 2'd1,
    PAT_LCG   = 2'd2,
    PAT_CONST = 2'd3
  } pat_mode_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_MODE      = 3'd0,
    REG_CHECK_ENABLE      = 3'd1,
    REG_EXPECTED_CHECKSUM = 3'd2,
    REG_MIN_ECHO_BYTES    = 3'd3,
    REG_HEADER_BYTES      = 3'd4,
    REG_MIN_FRAME_BYTES   = 3'd5,
    REG_MAX_FRAME_BYTES   = 3'd6
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [1:0]  RST_PATTERN_MODE      = 2'd1;
  localparam logic        RST_CHECK_ENABLE      = 1'b1;
  localparam logic [15:0] RST_EXPECTED_CHECKSUM = 16'hFFFF;
  localparam logic [7:0]  RST_MIN_ECHO_BYTES    = 8'd40;
  localparam logic [7:0]  RST_HEADER_BYTES      = 8'd30;
  localparam logic [15:0] RST_MIN_FRAME_BYTES   = 16'd60;
  localparam logic [15:0] RST_MAX_FRAME_BYTES   = 16'd1514;

  // echo reply code the type word must carry
  localparam logic [15:0] ECHO_REPLY_CODE = 16'd2;

  // pattern bits 23:16 only depend on the low 24 bits of the seed
  localparam int unsigned SEED_W  = 24;
  localparam logic [SEED_W-1:0] LCG_MUL = 24'(32'd1103515245);
  localparam logic [SEED_W-1:0] LCG_ADD = 24'(32'd12345);

  // stream widths
  localparam int unsigned S_TDATA_W = 128;
  localparam int unsigned M_TDATA_W = 8;

endpackage

`default_nettype wire

// ===== hw/rtl/echo_payload_pattern_checker_core.sv =====
// echo_payload_pattern_checker_core: judges returned echo replies, header checks
// followed by a payload compare against a generated byte pattern
// depends on ecpc_pkg
//
// usage:
//   s_* stream: one item per handshake. tuser selects the kind: header or
//   payload byte. a header runs checksum, length, frame size (ethernet only)
//   and reply type checks; the first failure gives a verdict right away.
//   a passing header arms the payload compare for expected_length minus
//   min_echo_bytes bytes; the verdict comes at the first mismatching byte or
//   after the last expected byte. payload bytes while not armed are dropped.
//   a header while armed abandons the packet in progress silently.
//   m_* stream: one verdict item, registered, in the cycle after the item
//   that caused it.
//   throughput: one item every cycle while no verdict waits; the lcg step is
//   kept one step ahead in a register, so each path has one constant multiply.
//   stall: s_tready = !m_tvalid || m_tready, so a new item is taken while a
//   verdict waits only if that verdict leaves in the same cycle.
//   cfg: write enable, register index, data; the user must write only while
//   idle, the block does not enforce it. reset (rst, synchronous) restores
//   register defaults, disarms the compare and drops any pending verdict.
`default_nettype none

module echo_payload_pattern_checker_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // tdata: expected_length[15:0], start_seed[47:16], reply_checksum[63:48],
  // reply_length[79:64], datagram_size[95:80], arrived_on_ether[96],
  // reply_type[112:97], payload_byte[120:113], zero fill[127:121]
  input  wire logic [ecpc_pkg::S_TDATA_W-1:0]   s_tdata,
  // tuser: command[0]
  input  wire logic                             s_tuser,
  // verdict stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // tdata: verdict[2:0], zero fill[7:3]
  output logic [ecpc_pkg::M_TDATA_W-1:0]        m_tdata,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [ecpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ecpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned SW = ecpc_pkg::SEED_W;

  // configuration registers
  ecpc_pkg::pat_mode_t pattern_mode;
  logic                check_enable;
  logic [15:0]         expected_checksum;
  logic [7:0]          min_echo_bytes;
  logic [7:0]          header_bytes;
  logic [15:0]         min_frame_bytes;
  logic [15:0]         max_frame_bytes;

  // packet state
  logic [SW-1:0]       pattern_seed, pattern_seed_next;
  logic [SW-1:0]       lcg_ahead, lcg_ahead_next;   // always seed * mul + add
  logic [15:0]         bytes_remaining, bytes_remaining_next;
  logic                checking_payload, checking_payload_next;

  // verdict output register
  ecpc_pkg::verdict_t  verdict, verdict_next;
  logic                emit;

  // unpacked input fields
  logic        command;
  logic [15:0] expected_length;
  logic [31:0] start_seed;
  logic [15:0] reply_checksum;
  logic [15:0] reply_length;
  logic [15:0] datagram_size;
  logic        arrived_on_ether;
  logic [15:0] reply_type;
  logic [7:0]  payload_byte;

  assign command          = s_tuser;
  assign expected_length  = s_tdata[15:0];
  assign start_seed       = s_tdata[47:16];
  assign reply_checksum   = s_tdata[63:48];
  assign reply_length     = s_tdata[79:64];
  assign datagram_size    = s_tdata[95:80];
  assign arrived_on_ether = s_tdata[96];
  assign reply_type       = s_tdata[112:97];
  assign payload_byte     = s_tdata[120:113];

  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // header checks, all compares in parallel, priority picks the first failure
  logic               bad_checksum, bad_length, bad_frame, bad_type;
  logic [8:0]         hdr_limit;
  ecpc_pkg::verdict_t hdr_verdict;
  logic [16:0]        payload_diff;
  logic [15:0]        payload_count;

  assign hdr_limit    = {1'b0, header_bytes} + 9'd2;
  assign bad_checksum = reply_checksum != expected_checksum;
  assign bad_length   = (expected_length != reply_length)
                     || (reply_length <= {7'd0, hdr_limit})
                     || (reply_length > datagram_size);
  assign bad_frame    = arrived_on_ether
                     && ((datagram_size < min_frame_bytes)
                      || (datagram_size > max_frame_bytes));
  assign bad_type     = reply_type != ecpc_pkg::ECHO_REPLY_CODE;

  always_comb begin
    if (bad_checksum) begin
      hdr_verdict = ecpc_pkg::VERDICT_CHECKSUM;
    end else if (bad_length) begin
      hdr_verdict = ecpc_pkg::VERDICT_LENGTH;
    end else if (bad_frame) begin
      hdr_verdict = ecpc_pkg::VERDICT_FRAME;
    end else if (bad_type) begin
      hdr_verdict = ecpc_pkg::VERDICT_TYPE;
    end else begin
      hdr_verdict = ecpc_pkg::VERDICT_GOOD;
    end
  end

  // payload count saturates at zero
  assign payload_diff  = {1'b0, expected_length} - {9'd0, min_echo_bytes};
  assign payload_count = payload_diff[16] ? 16'd0 : payload_diff[15:0];

  // lcg lookahead from the header seed, one constant multiply
  logic [SW-1:0] start_ahead;
  logic [SW-1:0] step_ahead;
  assign start_ahead = SW'(start_seed[SW-1:0] * ecpc_pkg::LCG_MUL) + ecpc_pkg::LCG_ADD;
  assign step_ahead  = SW'(lcg_ahead * ecpc_pkg::LCG_MUL) + ecpc_pkg::LCG_ADD;

  // expected pattern byte and seed advance for the current mode
  logic [7:0]    pattern_byte;
  logic [SW-1:0] seed_adv;
  logic [SW-1:0] ahead_adv;

  always_comb begin
    case (pattern_mode)
      ecpc_pkg::PAT_INCR: begin
        pattern_byte = pattern_seed[7:0];
        seed_adv     = pattern_seed + SW'(1);
        ahead_adv    = lcg_ahead + ecpc_pkg::LCG_MUL;
      end
      ecpc_pkg::PAT_LCG: begin
        pattern_byte = lcg_ahead[23:16];
        seed_adv     = lcg_ahead;
        ahead_adv    = step_ahead;
      end
      ecpc_pkg::PAT_CONST: begin
        pattern_byte = pattern_seed[7:0];
        seed_adv     = pattern_seed;
        ahead_adv    = lcg_ahead;
      end
      default: begin
        pattern_byte = 8'd0;
        seed_adv     = pattern_seed;
        ahead_adv    = lcg_ahead;
      end
    endcase
  end

  // next state for one accepted item
  always_comb begin
    pattern_seed_next     = pattern_seed;
    lcg_ahead_next        = lcg_ahead;
    bytes_remaining_next  = bytes_remaining;
    checking_payload_next = checking_payload;
    verdict_next          = ecpc_pkg::VERDICT_GOOD;
    emit                  = 1'b0;
    if (command == ecpc_pkg::CMD_HEADER) begin
      // a header always ends any packet in progress
      checking_payload_next = 1'b0;
      if (!check_enable) begin
        emit = 1'b1;
      end else if (hdr_verdict != ecpc_pkg::VERDICT_GOOD) begin
        emit         = 1'b1;
        verdict_next = hdr_verdict;
      end else begin
        bytes_remaining_next = payload_count;
        pattern_seed_next    = start_seed[SW-1:0];
        lcg_ahead_next       = start_ahead;
        if (payload_count == 16'd0) begin
          emit = 1'b1;
        end else begin
          checking_payload_next = 1'b1;
        end
      end
    end else if (checking_payload) begin
      pattern_seed_next = seed_adv;
      lcg_ahead_next    = ahead_adv;
      if (payload_byte != pattern_byte) begin
        emit                  = 1'b1;
        verdict_next          = ecpc_pkg::VERDICT_PAYLOAD;
        checking_payload_next = 1'b0;
        bytes_remaining_next  = 16'd0;
      end else begin
        bytes_remaining_next = bytes_remaining - 16'd1;
        if (bytes_remaining == 16'd1) begin
          // last expected byte matched
          emit                  = 1'b1;
          checking_payload_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode      <= ecpc_pkg::pat_mode_t'(ecpc_pkg::RST_PATTERN_MODE);
      check_enable      <= ecpc_pkg::RST_CHECK_ENABLE;
      expected_checksum <= ecpc_pkg::RST_EXPECTED_CHECKSUM;
      min_echo_bytes    <= ecpc_pkg::RST_MIN_ECHO_BYTES;
      header_bytes      <= ecpc_pkg::RST_HEADER_BYTES;
      min_frame_bytes   <= ecpc_pkg::RST_MIN_FRAME_BYTES;
      max_frame_bytes   <= ecpc_pkg::RST_MAX_FRAME_BYTES;
    end else if (cfg_we) begin
      case (ecpc_pkg::reg_index_t'(cfg_index))
        ecpc_pkg::REG_PATTERN_MODE:      pattern_mode <= ecpc_pkg::pat_mode_t'(cfg_data[1:0]);
        ecpc_pkg::REG_CHECK_ENABLE:      check_enable      <= cfg_data[0];
        ecpc_pkg::REG_EXPECTED_CHECKSUM: expected_checksum <= cfg_data;
        ecpc_pkg::REG_MIN_ECHO_BYTES:    min_echo_bytes    <= cfg_data[7:0];
        ecpc_pkg::REG_HEADER_BYTES:      header_bytes      <= cfg_data[7:0];
        ecpc_pkg::REG_MIN_FRAME_BYTES:   min_frame_bytes   <= cfg_data;
        ecpc_pkg::REG_MAX_FRAME_BYTES:   max_frame_bytes   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_seed     <= '0;
      lcg_ahead        <= ecpc_pkg::LCG_ADD;
      bytes_remaining  <= '0;
      checking_payload <= 1'b0;
      m_tvalid         <= 1'b0;
      verdict          <= ecpc_pkg::VERDICT_GOOD;
    end else begin
      if (accept) begin
        pattern_seed     <= pattern_seed_next;
        lcg_ahead        <= lcg_ahead_next;
        bytes_remaining  <= bytes_remaining_next;
        checking_payload <= checking_payload_next;
      end
      if (accept && emit) begin
        m_tvalid <= 1'b1;
        verdict  <= verdict_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'd0, verdict};

  // lookahead register always holds the next lcg state
  a_lcg_ahead: assert property (@(posedge clk) disable iff (rst)
    lcg_ahead == SW'(pattern_seed * ecpc_pkg::LCG_MUL) + ecpc_pkg::LCG_ADD)
    else $error("lcg lookahead out of step with seed");

  // an armed compare always has bytes left
  a_armed_count: assert property (@(posedge clk) disable iff (rst)
    checking_payload |-> bytes_remaining != 16'd0)
    else $error("payload compare armed with zero bytes left");

  // a header with checks off gives a good verdict next cycle
  a_unchecked_good: assert property (@(posedge clk) disable iff (rst)
    accept && command == ecpc_pkg::CMD_HEADER && !check_enable
    |=> m_tvalid && verdict == ecpc_pkg::VERDICT_GOOD && !checking_payload)
    else $error("unchecked header did not pass");

  // checksum failure wins over every other header check
  a_checksum_first: assert property (@(posedge clk) disable iff (rst)
    accept && command == ecpc_pkg::CMD_HEADER && check_enable && bad_checksum
    |=> m_tvalid && verdict == ecpc_pkg::VERDICT_CHECKSUM)
    else $error("checksum failure not reported");

endmodule

`default_nettype wire
